// ===== rtl/core/rphist_pkg.sv =====
// Shared types, constants and helper functions for the per-position
// base and quality histogram. No dependencies.
`default_nettype none

package rphist_pkg;

    localparam int MAX_POSITIONS = 512;
    localparam int BASE_KINDS    = 5;
    localparam int QUALITY_BINS  = 94;

    localparam int POS_W   = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int CODE_W  = 3;
    localparam int BIN_W   = 7;
    localparam int BASE_AW = POS_W + CODE_W;
    localparam int QUAL_AW = POS_W + BIN_W;
    localparam int BASE_DEPTH = 1 << BASE_AW;
    localparam int QUAL_DEPTH = 1 << QUAL_AW;

    localparam int CNT_W  = 32;
    localparam int PIR_W  = 10;
    localparam int LEN_W  = 10;
    localparam int ENC_W  = 2;
    localparam int CHAR_W = 8;
    localparam int RPOS_W = 9;
    localparam int CMP_W  = 14;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [PIR_W-1:0] PIR_SAT = '1;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(512);

    // offset, minimum value, maximum value per encoding
    localparam int ENC_TABLE [3][3] = '{'{33, 0, 93}, '{64, -5, 62}, '{64, 0, 62}};

    typedef enum logic [ENC_W-1:0] {
        ENC_SANGER   = 2'd0,
        ENC_SOLEXA   = 2'd1,
        ENC_ILLUMINA = 2'd2
    } enc_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_ACCUM   = 2'd0,
        ACT_RD_BASE = 2'd1,
        ACT_RD_QUAL = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_BAD_BASE = 3'd1,
        STAT_BAD_QUAL = 3'd2,
        STAT_TOO_LONG = 3'd3,
        STAT_BAD_ADDR = 3'd4
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_QUAL_ENC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 1'd1;

    typedef struct packed {
        logic    base_rd;
        logic    qual_rd;
        logic    base_wr;
        logic    qual_wr;
        status_t status;
    } cmd_t;

    function automatic logic [CHAR_W-1:0] enc_lo(input logic [ENC_W-1:0] enc);
        logic [CHAR_W-1:0] r;
        case (enc)
            ENC_SOLEXA:   r = CHAR_W'(ENC_TABLE[1][0] + ENC_TABLE[1][1]);
            ENC_ILLUMINA: r = CHAR_W'(ENC_TABLE[2][0] + ENC_TABLE[2][1]);
            default:      r = CHAR_W'(ENC_TABLE[0][0] + ENC_TABLE[0][1]);
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] enc_hi(input logic [ENC_W-1:0] enc);
        logic [CHAR_W-1:0] r;
        case (enc)
            ENC_SOLEXA:   r = CHAR_W'(ENC_TABLE[1][0] + ENC_TABLE[1][2]);
            ENC_ILLUMINA: r = CHAR_W'(ENC_TABLE[2][0] + ENC_TABLE[2][2]);
            default:      r = CHAR_W'(ENC_TABLE[0][0] + ENC_TABLE[0][2]);
        endcase
        return r;
    endfunction

    // valid flag in the top bit, base code below
    function automatic logic [CODE_W:0] base_code(input logic [CHAR_W-1:0] c);
        logic [CODE_W:0] r;
        case (c)
            "A":     r = {1'b1, CODE_W'(0)};
            "C":     r = {1'b1, CODE_W'(1)};
            "T":     r = {1'b1, CODE_W'(2)};
            "G":     r = {1'b1, CODE_W'(3)};
            "N":     r = {1'b1, CODE_W'(4)};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x == '1) ? x : x + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rphist_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rphist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rphist_decode.sv =====
// Item decode: base letter, quality window, length check, readout range
// and store addresses. Depends on rphist_pkg.
`default_nettype none

module rphist_decode
    import rphist_pkg::*;
(
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [CHAR_W-1:0] base_char,
    input  wire logic [CHAR_W-1:0] quality_char,
    input  wire logic [RPOS_W-1:0] read_position,
    input  wire logic [BIN_W-1:0]  read_bin,
    input  wire logic [PIR_W-1:0]  pos,
    input  wire logic [ENC_W-1:0]  enc,
    input  wire logic [LEN_W-1:0]  max_len,
    output cmd_t                   cmd,
    output logic [BASE_AW-1:0]     base_addr,
    output logic [QUAL_AW-1:0]     qual_addr
);

    logic [CODE_W:0]   code_full;
    logic              code_ok;
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] lo;
    logic [CHAR_W-1:0] hi;
    logic              qual_ok;
    logic [CHAR_W-1:0] bin_full;
    logic [BIN_W-1:0]  bin;
    logic              bin_fits;
    logic [CMP_W-1:0]  pos_w;
    logic [CMP_W-1:0]  rpos_w;
    logic              too_long;
    logic              rpos_bad;
    logic [POS_W-1:0]  pos_idx;
    logic [POS_W-1:0]  rpos_idx;

    always_comb begin
        code_full = base_code(base_char);
        code_ok   = code_full[CODE_W];
        code      = code_full[CODE_W-1:0];
        lo        = enc_lo(enc);
        hi        = enc_hi(enc);
        qual_ok   = !quality_char[CHAR_W-1] && (quality_char >= lo) && (quality_char <= hi);
        bin_full  = quality_char - lo;
        bin       = bin_full[BIN_W-1:0];
        bin_fits  = {1'b0, bin_full} < 9'(QUALITY_BINS);
        pos_w     = CMP_W'(pos);
        rpos_w    = CMP_W'(read_position);
        too_long  = (pos_w >= CMP_W'(max_len)) || (pos_w >= CMP_W'(MAX_POSITIONS));
        rpos_bad  = rpos_w >= CMP_W'(MAX_POSITIONS);
        pos_idx   = pos_w[POS_W-1:0];
        rpos_idx  = rpos_w[POS_W-1:0];

        cmd = '{base_rd: 1'b0, qual_rd: 1'b0, base_wr: 1'b0, qual_wr: 1'b0, status: STAT_OK};
        base_addr = {rpos_idx, read_bin[CODE_W-1:0]};
        qual_addr = {rpos_idx, read_bin};

        case (action)
            ACT_ACCUM: begin
                base_addr = {pos_idx, code};
                qual_addr = {pos_idx, bin};
                if (!code_ok) begin
                    cmd.status = STAT_BAD_BASE;
                end else if (!qual_ok) begin
                    cmd.status = STAT_BAD_QUAL;
                end else if (too_long) begin
                    cmd.status = STAT_TOO_LONG;
                end else begin
                    cmd.base_wr = 1'b1;
                    cmd.qual_wr = bin_fits;
                end
            end
            ACT_RD_BASE: begin
                if (rpos_bad || ({1'b0, read_bin} >= 8'(BASE_KINDS))) begin
                    cmd.status = STAT_BAD_ADDR;
                end else begin
                    cmd.base_rd = 1'b1;
                end
            end
            ACT_RD_QUAL: begin
                if (rpos_bad || ({1'b0, read_bin} >= 8'(QUALITY_BINS))) begin
                    cmd.status = STAT_BAD_ADDR;
                end else begin
                    cmd.qual_rd = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/read_position_base_quality_histogram.sv =====
// Top level of the per-position base and quality histogram.
// Depends on rphist_pkg, rphist_decode and rphist_ram.
//
// Usage:
//   s_ channel: one item per handshake. s_tuser selects the action
//   (accumulate a base and its quality, read a base count, read a quality
//   count, or none), s_tlast ends a read. m_ channel: one result per item,
//   status on m_tuser and the count on m_tdata. cfg_ channel writes the
//   quality encoding (index 0) and the tracked read length (index 1).
//   Result: an accepted item waits in the EXEC state until the output
//   register is free; it is then loaded there and m_tvalid rises.
//   Flow: a new item is accepted only after the last one has left EXEC,
//   set by the read-modify-write of the count memories (registered read,
//   write back in EXEC). Reset: the counts are cleared by a pass over
//   the quality memory, one entry per cycle, with the base memory
//   cleared alongside; s_tready stays low during the pass.
//   Stall: a result held by m_tready low does not block the next accept;
//   that item waits after its memory read until the output register frees.
`default_nettype none

module read_position_base_quality_histogram
    import rphist_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,   // base_char, quality_char, read_position, read_bin
    input  wire logic [ACT_W-1:0]     s_tuser,   // action
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [CNT_W-1:0]          m_tdata,   // count
    output logic [STAT_W-1:0]         m_tuser,   // status
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        FSM_CLEAR = 3'b001,
        FSM_IDLE  = 3'b010,
        FSM_EXEC  = 3'b100
    } fsm_t;

    fsm_t               fsm_reg, fsm_next;
    logic [PIR_W-1:0]   pir_reg, pir_next;
    logic [ENC_W-1:0]   enc_reg, enc_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [QUAL_AW-1:0] clr_reg, clr_next;
    cmd_t               cmd_reg, cmd_next;
    logic [BASE_AW-1:0] base_addr_reg, base_addr_next;
    logic [QUAL_AW-1:0] qual_addr_reg, qual_addr_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]  m_tuser_reg, m_tuser_next;

    cmd_t               dec_cmd;
    logic [BASE_AW-1:0] dec_base_addr;
    logic [QUAL_AW-1:0] dec_qual_addr;
    logic               s_accept;
    logic               out_free;
    logic               exec_go;
    logic               clearing;

    logic               base_we, qual_we;
    logic [BASE_AW-1:0] base_waddr;
    logic [QUAL_AW-1:0] qual_waddr;
    logic [CNT_W-1:0]   base_wdata, qual_wdata;
    logic [CNT_W-1:0]   base_rdata, qual_rdata;

    rphist_decode u_decode (
        .action        (s_tuser),
        .base_char     (s_tdata[7:0]),
        .quality_char  (s_tdata[15:8]),
        .read_position (s_tdata[24:16]),
        .read_bin      (s_tdata[31:25]),
        .pos           (pir_reg),
        .enc           (enc_reg),
        .max_len       (len_reg),
        .cmd           (dec_cmd),
        .base_addr     (dec_base_addr),
        .qual_addr     (dec_qual_addr)
    );

    rphist_ram #(.WIDTH(CNT_W), .DEPTH(BASE_DEPTH)) u_base_ram (
        .aclk  (aclk),
        .we    (base_we),
        .waddr (base_waddr),
        .wdata (base_wdata),
        .re    (s_accept),
        .raddr (dec_base_addr),
        .rdata (base_rdata)
    );

    rphist_ram #(.WIDTH(CNT_W), .DEPTH(QUAL_DEPTH)) u_qual_ram (
        .aclk  (aclk),
        .we    (qual_we),
        .waddr (qual_waddr),
        .wdata (qual_wdata),
        .re    (s_accept),
        .raddr (dec_qual_addr),
        .rdata (qual_rdata)
    );

    assign s_tready  = (fsm_reg == FSM_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign exec_go   = (fsm_reg == FSM_EXEC) && out_free;
    assign clearing  = (fsm_reg == FSM_CLEAR);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb begin
        base_we    = clearing || (exec_go && cmd_reg.base_wr);
        qual_we    = clearing || (exec_go && cmd_reg.qual_wr);
        base_waddr = clearing ? clr_reg[BASE_AW-1:0] : base_addr_reg;
        qual_waddr = clearing ? clr_reg : qual_addr_reg;
        base_wdata = clearing ? '0 : sat_inc(base_rdata);
        qual_wdata = clearing ? '0 : sat_inc(qual_rdata);
    end

    always_comb begin
        fsm_next       = fsm_reg;
        pir_next       = pir_reg;
        enc_next       = enc_reg;
        len_next       = len_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        base_addr_next = base_addr_reg;
        qual_addr_next = qual_addr_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_QUAL_ENC: enc_next = cfg_data[ENC_W-1:0];
                CFG_MAX_LEN:  len_next = cfg_data;
                default: begin
                end
            endcase
        end

        case (fsm_reg)
            FSM_CLEAR: begin
                clr_next = clr_reg + QUAL_AW'(1);
                if (clr_reg == '1) begin
                    fsm_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                if (s_accept) begin
                    cmd_next       = dec_cmd;
                    base_addr_next = dec_base_addr;
                    qual_addr_next = dec_qual_addr;
                    fsm_next       = FSM_EXEC;
                    if (s_tuser == ACT_ACCUM) begin
                        if (s_tlast) begin
                            pir_next = '0;
                        end else if (pir_reg != PIR_SAT) begin
                            pir_next = pir_reg + PIR_W'(1);
                        end
                    end
                end
            end
            FSM_EXEC: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = cmd_reg.status;
                    if (cmd_reg.base_rd) begin
                        m_tdata_next = base_rdata;
                    end else if (cmd_reg.qual_rd) begin
                        m_tdata_next = qual_rdata;
                    end else begin
                        m_tdata_next = '0;
                    end
                    fsm_next = FSM_IDLE;
                end
            end
            default: begin
                fsm_next = FSM_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= FSM_CLEAR;
            pir_reg      <= '0;
            enc_reg      <= ENC_SANGER;
            len_reg      <= LEN_RESET;
            clr_reg      <= '0;
            cmd_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            fsm_reg      <= fsm_next;
            pir_reg      <= pir_next;
            enc_reg      <= enc_next;
            len_reg      <= len_next;
            clr_reg      <= clr_next;
            cmd_reg      <= cmd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_addr_reg <= base_addr_next;
        qual_addr_reg <= qual_addr_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/rphist_checker.sv =====
// Port-level checks for the histogram top level, attached by bind.
// Depends on rphist_pkg and read_position_base_quality_histogram.
`default_nettype none

module rphist_checker
    import rphist_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [CNT_W-1:0]     m_tdata,
    input wire logic [STAT_W-1:0]    m_tuser
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("item accepted while another is in flight");

    a_result_due: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (!m_tvalid || m_tready) |=> ##1 m_tvalid)
        else $error("result missing two cycles after accept");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= STAT_BAD_ADDR))
        else $error("status code out of range");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("nonzero count with error status");

endmodule

bind read_position_base_quality_histogram rphist_checker u_rphist_checker (.*);

`default_nettype wire
